// ===== hw/rtl/signed_int_to_radix_text_defines.svh =====
// Assertion macros shared by the checker of the radix text converter.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef SIGNED_INT_TO_RADIX_TEXT_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_TEXT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sirt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SIRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sirt assertion failed");

`endif

// ===== hw/rtl/sirt_pkg.sv =====
// Shared types, constants and helpers for the radix text converter.
// Used by every RTL file of the block; depends on nothing.
package sirt_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MAX_RADIX  = 32;
  localparam int unsigned SYM_COUNT  = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned DIGIT_W    = 5;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned SYM_WORDS  = 4;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_LOW   = 8'd32;
  localparam logic [7:0] CHAR_HIGH  = 8'd126;
  localparam logic [7:0] CHAR_NONE  = 8'd0;
  localparam logic [LEN_W-1:0] MIN_RADIX = 6'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_3    = 3'd4;

  typedef logic [SYM_COUNT-1:0][7:0] sym_array_t;
  typedef logic [SYM_WORDS-1:0][CFG_DATA_W-1:0] sym_words_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_DIGITS,
    ST_BAD
  } sirt_state_e;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [LEN_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_rsp_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_rsp_t;

  function automatic logic [7:0] symbol_at(sym_array_t syms, logic [DIGIT_W-1:0] idx);
    return syms[idx];
  endfunction

endpackage

// ===== hw/rtl/signed_int_to_radix_text.sv =====
// Signed integer to radix text converter. Each input word carries one signed 32-bit
// value; the block answers with its text in the configured radix, one character per
// output word: a minus sign for negative values, then the digits from most to least
// significant, tlast on the final one. Before each value the alphabet (radix_length
// symbols) is checked one symbol per cycle; a bad alphabet gives a single word with
// tuser set, tdata zero and tlast set. Each digit comes from the shared
// one-bit-per-cycle divider, and the characters go out once all digits are known,
// as output stalls allow. The input is not ready while a value is being converted.
// Depends on sirt_pkg, sirt_divider and sirt_alpha_check.
module signed_int_to_radix_text (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sirt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sirt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // [31:0] number
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] out_char
  output logic                           m_axis_tlast,
  output logic [0:0]                     m_axis_tuser    // [0] bad_alphabet
);
  import sirt_pkg::*;

  sirt_state_e           state_q, state_d;
  logic [LEN_W-1:0]      radix_len_q;
  sym_words_t            sym_words_q;
  sym_array_t            syms;
  logic [VALUE_BITS-1:0] in_q, in_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      cnt_inc;
  logic [DIGIT_W-1:0]    dig_idx;
  logic [DIGIT_W-1:0]    digits_q [SYM_COUNT];
  logic [DIGIT_W-1:0]    dig_rd_q;
  logic                  dig_we;
  logic                  ovalid_q, ovalid_d;
  logic [7:0]            ochar_q, ochar_d;
  logic                  olast_q, olast_d;
  logic                  obad_q, obad_d;
  logic                  load;
  logic                  chk_start;
  logic                  div_start;
  chk_rsp_t              chk_rsp;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign syms        = sym_array_t'(sym_words_q);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_len_q <= '0;
      sym_words_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RADIX_LENGTH: radix_len_q    <= cfg_data_i[LEN_W-1:0];
        REG_SYMBOLS_0:    sym_words_q[0] <= cfg_data_i;
        REG_SYMBOLS_1:    sym_words_q[1] <= cfg_data_i;
        REG_SYMBOLS_2:    sym_words_q[2] <= cfg_data_i;
        REG_SYMBOLS_3:    sym_words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sirt_alpha_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (chk_start),
    .len_i   (radix_len_q),
    .syms_i  (syms),
    .rsp_o   (chk_rsp)
  );

  sirt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cnt_inc       = cnt_q + 1'b1;
  assign dig_idx       = DIGIT_W'(cnt_d - 1'b1);
  assign load          = !ovalid_q || m_axis_tready;
  assign div_req       = '{start: div_start, dividend: mag_q, divisor: radix_len_q};
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    in_d      = in_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    cnt_d     = cnt_q;
    dig_we    = 1'b0;
    chk_start = 1'b0;
    div_start = 1'b0;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ochar_d   = ochar_q;
    olast_d   = olast_q;
    obad_d    = obad_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          in_d      = s_axis_tdata;
          chk_start = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_rsp.done) begin
          if (chk_rsp.ok) begin
            neg_d   = in_q[VALUE_BITS-1];
            mag_d   = in_q[VALUE_BITS-1] ? ('0 - in_q) : in_q;
            cnt_d   = '0;
            state_d = ST_DIV_START;
          end else begin
            state_d = ST_BAD;
          end
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          dig_we = 1'b1;
          mag_d  = div_rsp.quotient;
          cnt_d  = cnt_inc;
          if ((div_rsp.quotient != '0) && (cnt_inc < CNT_W'(VALUE_BITS))) begin
            state_d = ST_DIV_START;
          end else if (neg_q) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_DIGITS;
          end
        end
      end
      ST_SIGN: begin
        if (load) begin
          ovalid_d = 1'b1;
          ochar_d  = CHAR_MINUS;
          olast_d  = 1'b0;
          obad_d   = 1'b0;
          state_d  = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (load) begin
          ovalid_d = 1'b1;
          ochar_d  = symbol_at(syms, dig_rd_q);
          olast_d  = (cnt_q == CNT_W'(1));
          obad_d   = 1'b0;
          cnt_d    = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_BAD: begin
        if (load) begin
          ovalid_d = 1'b1;
          ochar_d  = CHAR_NONE;
          olast_d  = 1'b1;
          obad_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      neg_q    <= 1'b0;
      mag_q    <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      cnt_q    <= cnt_d;
    end
  end

  // The digit read is registered at the address needed in the next cycle; a digit
  // written in this cycle is forwarded straight to the read register.
  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    obad_q  <= obad_d;
    if (dig_we) begin
      digits_q[cnt_q[DIGIT_W-1:0]] <= div_rsp.remainder;
      dig_rd_q                     <= div_rsp.remainder;
    end else begin
      dig_rd_q <= digits_q[dig_idx];
    end
  end

  assign m_axis_tvalid   = ovalid_q;
  assign m_axis_tdata    = ochar_q;
  assign m_axis_tlast    = olast_q;
  assign m_axis_tuser[0] = obad_q;

endmodule

// ===== hw/rtl/sirt_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on sirt_pkg.
module sirt_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sirt_pkg::div_req_t req_i,
  output sirt_pkg::div_rsp_t rsp_o
);
  import sirt_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIGIT_W-1:0]    cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [LEN_W-1:0]      div_q, div_d;
  logic [LEN_W-1:0]      trial;
  logic [LEN_W-1:0]      diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign ge    = trial >= div_q;
  assign diff  = trial - div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], ge};
      rem_d = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIGIT_W'(VALUE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== hw/rtl/sirt_alpha_check.sv =====
// Alphabet checker that walks the symbols one per cycle.
// Depends on sirt_pkg.
module sirt_alpha_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sirt_pkg::LEN_W-1:0] len_i,
  input  sirt_pkg::sym_array_t       syms_i,
  output sirt_pkg::chk_rsp_t         rsp_o
);
  import sirt_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               ok_q, ok_d;
  logic [DIGIT_W-1:0] idx_q, idx_d;
  logic [7:0]         cur;
  logic               bad_char;
  logic               dup;
  logic               at_end;

  assign cur      = symbol_at(syms_i, idx_q);
  assign bad_char = (cur == CHAR_PLUS) || (cur == CHAR_MINUS) ||
                    (cur < CHAR_LOW) || (cur > CHAR_HIGH);
  assign at_end   = {1'b0, idx_q} == (len_i - 1'b1);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < SYM_COUNT; j++) begin
      if ((DIGIT_W'(j) > idx_q) && (LEN_W'(j) < len_i) && (syms_i[j] == cur)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ok_d   = ok_q;
    idx_d  = idx_q;
    if (start_i) begin
      idx_d = '0;
      if ((len_i < MIN_RADIX) || (len_i > LEN_W'(MAX_RADIX))) begin
        done_d = 1'b1;
        ok_d   = 1'b0;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (bad_char || dup) begin
        done_d = 1'b1;
        ok_d   = 1'b0;
        busy_d = 1'b0;
      end else if (at_end) begin
        done_d = 1'b1;
        ok_d   = 1'b1;
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ok_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ok_q   <= ok_d;
      idx_q  <= idx_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ok   = ok_q;

endmodule

// ===== hw/rtl/sirt_checker.sv =====
// Port-level checker for the radix text converter, bound to the top level.
// Depends on sirt_pkg and signed_int_to_radix_text_defines.svh.
`include "signed_int_to_radix_text_defines.svh"

module sirt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [sirt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [31:0]                     s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [7:0]                      m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic [0:0]                      m_axis_tuser
);
  import sirt_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_valid_i ^ cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i) ^
                     (^s_axis_tdata);

  // A flagged word stands alone: zero character and end of text.
  `SIRT_ASSERT_SAME(a_bad_word_form, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == CHAR_NONE))

  // Once a value is taken, the block is busy converting it.
  `SIRT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // While text is still being sent, no new value is taken.
  `SIRT_ASSERT_SAME(a_no_input_mid_text, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

  // A stalled word holds its contents.
  `SIRT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind signed_int_to_radix_text sirt_checker u_sirt_checker (.*);

// ===== tb/signed_int_to_radix_text_tb.sv =====
// Self-checking testbench for the signed integer to radix text converter.
// Depends on sirt_pkg and the signed_int_to_radix_text top level with its submodules.
module signed_int_to_radix_text_tb;
  import sirt_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } text_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic [0:0]            m_axis_tuser;

  text_word_t       expected_text[$];
  logic [LEN_W-1:0] radix_len;
  sym_words_t       shadow_words;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               error_count;

  signed_int_to_radix_text DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [7:0] sym_byte(input int unsigned idx);
    sym_array_t syms;
    syms = sym_array_t'(shadow_words);
    return syms[idx % SYM_COUNT];
  endfunction

  function automatic bit alphabet_valid();
    logic [7:0] c;
    if (radix_len < MIN_RADIX || radix_len > MAX_RADIX || radix_len > SYM_COUNT) return 1'b0;
    for (int i = 0; i < radix_len; i++) begin
      c = sym_byte(i);
      if (c == CHAR_PLUS || c == CHAR_MINUS || c < CHAR_LOW || c > CHAR_HIGH) return 1'b0;
      for (int j = i + 1; j < radix_len; j++) begin
        if (sym_byte(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic [31:0] value);
    logic [DIGIT_W-1:0] digits [VALUE_BITS];
    int unsigned        mag;
    int unsigned        base;
    int unsigned        n;
    logic               negative;
    if (!alphabet_valid()) begin
      expected_text.push_back('{ch: CHAR_NONE, last: 1'b1, bad: 1'b1});
      return;
    end
    base = radix_len;
    negative = value[31];
    mag = negative ? -value : value;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < VALUE_BITS);
    if (negative) expected_text.push_back('{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      expected_text.push_back('{ch: sym_byte(digits[i]), last: (i == 0), bad: 1'b0});
    end
  endfunction

  function automatic sym_array_t text_symbols(input string s);
    sym_array_t syms;
    syms = '0;
    for (int i = 0; i < s.len(); i++) syms[i] = s[i];
    return syms;
  endfunction

  function automatic void random_alphabet(output logic [LEN_W-1:0] len, output sym_array_t syms);
    logic [7:0] pool[$];
    int         k;
    for (int c = CHAR_LOW; c <= CHAR_HIGH; c++) begin
      if (c != CHAR_PLUS && c != CHAR_MINUS) pool.push_back(8'(c));
    end
    for (int i = 0; i < SYM_COUNT; i++) syms[i] = 8'($urandom());
    case ($urandom_range(0, 3))
      0: len = MIN_RADIX;
      1: len = LEN_W'(SYM_COUNT);
      default: len = LEN_W'($urandom_range(3, SYM_COUNT - 1));
    endcase
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(0, pool.size() - 1);
      syms[i] = pool[k];
      pool.delete(k);
    end
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 4))
        0: len = LEN_W'($urandom_range(0, 1));
        1: len = LEN_W'($urandom_range(SYM_COUNT + 1, 2**LEN_W - 1));
        2: syms[$urandom_range(1, len - 1)] = syms[0];
        3: syms[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
        default: syms[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ?
                   8'($urandom_range(0, CHAR_LOW - 1)) : 8'($urandom_range(CHAR_HIGH + 1, 255));
      endcase
    end
  endfunction

  function automatic logic [31:0] random_number();
    case ($urandom_range(0, 6))
      0, 1, 2: return $urandom();
      3: return $urandom_range(0, 1000);
      4: return -$urandom_range(0, 1000);
      5: return $urandom() >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0001;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_RADIX_LENGTH) begin
      radix_len = data[LEN_W-1:0];
    end else if (idx >= REG_SYMBOLS_0 && idx <= REG_SYMBOLS_3) begin
      shadow_words[idx - REG_SYMBOLS_0] = data;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_symbols(input logic [LEN_W-1:0] len, input sym_array_t syms);
    logic [CFG_DATA_W-1:0] len_word;
    sym_words_t            words;
    len_word = {$urandom(), $urandom()};
    len_word[LEN_W-1:0] = len;
    words = sym_words_t'(syms);
    write_reg(REG_RADIX_LENGTH, len_word);
    for (int w = 0; w < SYM_WORDS; w++) write_reg(REG_SYMBOLS_0 + CFG_IDX_W'(w), words[w]);
  endtask

  task automatic send_number(input logic [31:0] value);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_text(value);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_words
    text_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_text.size() == 0) begin
        if (error_count < 10) begin
          $display("unexpected word: char %h last %b bad %b",
                   m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end
        error_count++;
      end else begin
        want = expected_text.pop_front();
        if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last ||
            m_axis_tuser[0] !== want.bad) begin
          if (error_count < 10) begin
            $display("mismatch: expected char %h last %b bad %b, got char %h last %b bad %b",
                     want.ch, want.last, want.bad, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
          end
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_alphabet();
    send_number(32'd5);
    wait_until_drained();
  endtask

  task automatic test_decimal_text();
    load_symbols(LEN_W'(10), text_symbols("0123456789"));
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(-32'sd10);
    wait_until_drained();
    // Writes to indexes past the last register must leave the setup alone.
    for (int r = REG_SYMBOLS_3 + 1; r < 2**CFG_IDX_W; r++) begin
      write_reg(CFG_IDX_W'(r), {$urandom(), $urandom()});
    end
    send_number(32'd123456789);
    wait_until_drained();
  endtask

  task automatic test_binary_edges();
    load_symbols(MIN_RADIX, text_symbols(" ~"));
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
    wait_until_drained();
  endtask

  task automatic test_radix32_text();
    load_symbols(LEN_W'(SYM_COUNT), text_symbols("0123456789ABCDEFGHIJKLMNOPQRSTUV"));
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd31);
    send_number(32'd32);
    wait_until_drained();
  endtask

  task automatic try_bad_alphabet(input logic [LEN_W-1:0] len, input sym_array_t syms);
    load_symbols(len, syms);
    send_number($urandom());
    wait_until_drained();
  endtask

  task automatic test_bad_alphabets();
    sym_array_t syms;
    try_bad_alphabet(LEN_W'(1), text_symbols("0"));
    try_bad_alphabet(LEN_W'(SYM_COUNT + 1), text_symbols("0123456789ABCDEFGHIJKLMNOPQRSTUV"));
    try_bad_alphabet(LEN_W'(2**LEN_W - 1), text_symbols("0123456789"));
    try_bad_alphabet(LEN_W'(4), text_symbols("0120"));
    try_bad_alphabet(LEN_W'(4), text_symbols("01+3"));
    try_bad_alphabet(LEN_W'(4), text_symbols("-123"));
    syms = text_symbols("012");
    syms[1] = CHAR_LOW - 8'd1;
    try_bad_alphabet(LEN_W'(3), syms);
    syms[1] = CHAR_HIGH + 8'd1;
    try_bad_alphabet(LEN_W'(3), syms);
  endtask

  task automatic test_random_streams();
    logic [LEN_W-1:0] len;
    sym_array_t       syms;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 3; p++) begin
        random_alphabet(len, syms);
        load_symbols(len, syms);
        repeat (22) send_number(random_number());
        wait_until_drained();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    radix_len     = '0;
    shadow_words  = '0;
    send_idle_pct = 38;
    recv_idle_pct = 46;
    error_count   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_alphabet();
    test_decimal_text();
    test_binary_edges();
    test_radix32_text();
    test_bad_alphabets();
    test_random_streams();

    wait_until_drained();
    repeat (1200) @(negedge clk_i);
    if (error_count == 0) begin
      $display("[signed_int_to_radix_text] OK");
    end else begin
      $display("[signed_int_to_radix_text] ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[signed_int_to_radix_text] ERROR");
    $finish;
  end

endmodule
